@@ hw/rtl/armq_pkg.sv @@
// Package for the acknowledged-message retransmission queue.
// Holds field widths, item kind and result status codes, and the entry type.
// No dependencies.
package armq_pkg;

  localparam int unsigned QueueDepthDefault = 32;

  localparam int unsigned KindW    = 2;
  localparam int unsigned TypeW    = 8;
  localparam int unsigned ObjectW  = 16;
  localparam int unsigned AddressW = 32;
  localparam int unsigned TransW   = 16;
  localparam int unsigned PayloadW = 16;
  localparam int unsigned AgeW     = 4;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned CfgW     = 4;
  localparam int unsigned CfgIdxW  = 1;

  localparam logic [AgeW-1:0] AgeMax          = 4'd15;
  localparam logic [CfgW-1:0] RetryFirstReset = 4'd2;
  localparam logic [CfgW-1:0] GiveUpReset     = 4'd6;

  typedef enum logic [KindW-1:0] {
    KIND_ENQ    = 2'd0,
    KIND_ACK    = 2'd1,
    KIND_TICK   = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_REPLACED    = 3'd0,
    ST_STORED      = 3'd1,
    ST_OVERWROTE   = 3'd2,
    ST_ACK_MATCH   = 3'd3,
    ST_ACK_NOMATCH = 3'd4,
    ST_RETRY       = 3'd5,
    ST_TICK_DONE   = 3'd6
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RETRY_FIRST = 1'd0,
    CFG_GIVE_UP     = 1'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    FSM_IDLE   = 2'd0,
    FSM_SCAN   = 2'd1,
    FSM_FINISH = 2'd2
  } fsm_e;

  typedef struct packed {
    logic [TypeW-1:0]    msg_type;
    logic [ObjectW-1:0]  object;
    logic [AddressW-1:0] address;
    logic [TransW-1:0]   transaction;
    logic [PayloadW-1:0] payload;
    logic [AgeW-1:0]     age;
  } entry_t;

endpackage

@@ hw/rtl/ack_retry_message_queue.sv @@
// Top level of the acknowledged-message retransmission queue.
// Depends on armq_pkg for widths, codes and the entry type.
// Holds the entry memory, the live bits and the scan sequencer.

// Each accepted item walks the entry memory one slot per cycle through a single
// read port and one compare unit; an enqueue or an acknowledgement ends early
// at the first matching live entry, and a kind 3 item is dropped without
// raising busy. Results leave on result_valid_o for exactly one cycle each and
// cannot be held off: an enqueue or acknowledgement gives one result, a retry
// tick gives one retry result per resent entry in slot order and then a
// tick-done result, with last_o marking the final one. Reset needs no clearing
// pass; per-slot live bits cleared by reset mark the free slots. Configuration
// may be written only while busy is low.
module ack_retry_message_queue #(
  parameter int unsigned QUEUE_DEPTH = armq_pkg::QueueDepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [armq_pkg::KindW-1:0]    kind_i,
  input  logic [armq_pkg::TypeW-1:0]    msg_type_i,
  input  logic [armq_pkg::ObjectW-1:0]  object_id_i,
  input  logic [armq_pkg::AddressW-1:0] dest_address_i,
  input  logic [armq_pkg::TransW-1:0]   transaction_i,
  input  logic [armq_pkg::PayloadW-1:0] payload_tag_i,
  input  logic                          cfg_we_i,
  input  logic [armq_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [armq_pkg::CfgW-1:0]     cfg_data_i,
  output logic                          result_valid_o,
  output logic [armq_pkg::StatusW-1:0]  status_o,
  output logic [armq_pkg::TypeW-1:0]    out_type_o,
  output logic [armq_pkg::ObjectW-1:0]  out_object_o,
  output logic [armq_pkg::AddressW-1:0] out_address_o,
  output logic [armq_pkg::TransW-1:0]   out_transaction_o,
  output logic [armq_pkg::PayloadW-1:0] out_payload_o,
  output logic                          last_o
);
  import armq_pkg::*;

  localparam int unsigned IdxW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CntW-1:0] CntEnd  = CntW'(QUEUE_DEPTH);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(QUEUE_DEPTH - 1);

  entry_t mem [QUEUE_DEPTH];

  fsm_e                 state_q, state_d;
  kind_e                kind_q, kind_d;
  entry_t               in_q, in_d;
  logic [CntW-1:0]      idx_q, idx_d;
  logic                 ev_vld_q, ev_vld_d;
  logic [IdxW-1:0]      ev_idx_q;
  logic                 ev_live_q;
  entry_t               ev_data_q;
  logic                 free_found_q, free_found_d;
  logic [IdxW-1:0]      free_idx_q, free_idx_d;
  logic [QUEUE_DEPTH-1:0] live_q, live_d;
  logic [CfgW-1:0]      retry_first_q, retry_first_d;
  logic [CfgW-1:0]      give_up_q, give_up_d;
  logic                 res_valid_q, res_valid_d;
  status_e              res_status_q, res_status_d;
  entry_t               res_entry_q, res_entry_d;
  logic                 res_last_q, res_last_d;

  logic                 issue;
  logic                 mem_we;
  logic [IdxW-1:0]      mem_waddr;
  entry_t               mem_wdata;

  always_comb begin
    logic            ev_last;
    logic            stop;
    logic [AgeW-1:0] age_new;
    logic [IdxW-1:0] slot;
    logic            any_free;

    state_d       = state_q;
    kind_d        = kind_q;
    in_d          = in_q;
    idx_d         = idx_q;
    ev_vld_d      = 1'b0;
    free_found_d  = free_found_q;
    free_idx_d    = free_idx_q;
    live_d        = live_q;
    retry_first_d = retry_first_q;
    give_up_d     = give_up_q;
    res_valid_d   = 1'b0;
    res_status_d  = res_status_q;
    res_entry_d   = res_entry_q;
    res_last_d    = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = ev_idx_q;
    mem_wdata     = ev_data_q;
    issue         = 1'b0;
    stop          = 1'b0;
    ev_last       = ev_vld_q && (ev_idx_q == IdxLast);
    age_new       = (ev_data_q.age == AgeMax) ? ev_data_q.age : ev_data_q.age + 1'b1;
    slot          = '0;
    any_free      = 1'b0;

    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_RETRY_FIRST: retry_first_d = cfg_data_i;
        CFG_GIVE_UP:     give_up_d = cfg_data_i;
        default: ;
      endcase
    end

    unique case (state_q)
      FSM_IDLE: begin
        if (start && (kind_i != KIND_UNUSED)) begin
          kind_d       = kind_e'(kind_i);
          in_d         = '{msg_type: msg_type_i, object: object_id_i,
                           address: dest_address_i, transaction: transaction_i,
                           payload: payload_tag_i, age: '0};
          idx_d        = '0;
          free_found_d = 1'b0;
          free_idx_d   = '0;
          state_d      = FSM_SCAN;
        end
      end
      FSM_SCAN: begin
        if (ev_vld_q) begin
          unique case (kind_q)
            KIND_ENQ: begin
              if (ev_live_q && (ev_data_q.msg_type == in_q.msg_type) &&
                  (ev_data_q.object == in_q.object) &&
                  (ev_data_q.address == in_q.address)) begin
                stop         = 1'b1;
                mem_we       = 1'b1;
                mem_wdata    = in_q;
                res_valid_d  = 1'b1;
                res_status_d = ST_REPLACED;
                res_entry_d  = '0;
                res_last_d   = 1'b1;
                state_d      = FSM_IDLE;
              end else begin
                if (!ev_live_q && !free_found_q) begin
                  free_found_d = 1'b1;
                  free_idx_d   = ev_idx_q;
                end
                if (ev_last) begin
                  any_free = free_found_q || !ev_live_q;
                  if (free_found_q) begin
                    slot = free_idx_q;
                  end else if (!ev_live_q) begin
                    slot = ev_idx_q;
                  end
                  mem_we       = 1'b1;
                  mem_waddr    = slot;
                  mem_wdata    = in_q;
                  live_d[slot] = (in_q.msg_type != '0);
                  res_valid_d  = 1'b1;
                  res_status_d = any_free ? ST_STORED : ST_OVERWROTE;
                  res_entry_d  = '0;
                  res_last_d   = 1'b1;
                  state_d      = FSM_IDLE;
                end
              end
            end
            KIND_ACK: begin
              if (ev_live_q && (ev_data_q.transaction == in_q.transaction)) begin
                stop             = 1'b1;
                live_d[ev_idx_q] = 1'b0;
                res_valid_d      = 1'b1;
                res_status_d     = ST_ACK_MATCH;
                res_entry_d      = '0;
                res_last_d       = 1'b1;
                state_d          = FSM_IDLE;
              end else if (ev_last) begin
                res_valid_d  = 1'b1;
                res_status_d = ST_ACK_NOMATCH;
                res_entry_d  = '0;
                res_last_d   = 1'b1;
                state_d      = FSM_IDLE;
              end
            end
            KIND_TICK: begin
              if (ev_live_q) begin
                mem_we        = 1'b1;
                mem_wdata.age = age_new;
                if ((age_new >= retry_first_q) && (age_new < give_up_q)) begin
                  res_valid_d     = 1'b1;
                  res_status_d    = ST_RETRY;
                  res_entry_d     = ev_data_q;
                  res_entry_d.age = '0;
                end else if (age_new >= give_up_q) begin
                  live_d[ev_idx_q] = 1'b0;
                end
              end
              if (ev_last) begin
                state_d = FSM_FINISH;
              end
            end
            default: ;
          endcase
        end
        if (!stop && (idx_q != CntEnd)) begin
          issue    = 1'b1;
          idx_d    = idx_q + 1'b1;
          ev_vld_d = 1'b1;
        end
      end
      FSM_FINISH: begin
        res_valid_d  = 1'b1;
        res_status_d = ST_TICK_DONE;
        res_entry_d  = '0;
        res_last_d   = 1'b1;
        state_d      = FSM_IDLE;
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= FSM_IDLE;
      kind_q        <= KIND_ENQ;
      idx_q         <= '0;
      ev_vld_q      <= 1'b0;
      free_found_q  <= 1'b0;
      free_idx_q    <= '0;
      live_q        <= '0;
      retry_first_q <= RetryFirstReset;
      give_up_q     <= GiveUpReset;
      res_valid_q   <= 1'b0;
      res_last_q    <= 1'b0;
      res_status_q  <= ST_REPLACED;
    end else begin
      state_q       <= state_d;
      kind_q        <= kind_d;
      idx_q         <= idx_d;
      ev_vld_q      <= ev_vld_d;
      free_found_q  <= free_found_d;
      free_idx_q    <= free_idx_d;
      live_q        <= live_d;
      retry_first_q <= retry_first_d;
      give_up_q     <= give_up_d;
      res_valid_q   <= res_valid_d;
      res_last_q    <= res_last_d;
      res_status_q  <= res_status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q        <= in_d;
    res_entry_q <= res_entry_d;
    if (issue) begin
      ev_idx_q  <= idx_q[IdxW-1:0];
      ev_live_q <= live_q[idx_q[IdxW-1:0]];
      ev_data_q <= mem[idx_q[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  assign busy              = (state_q != FSM_IDLE);
  assign result_valid_o    = res_valid_q;
  assign status_o          = res_status_q;
  assign out_type_o        = res_entry_q.msg_type;
  assign out_object_o      = res_entry_q.object;
  assign out_address_o     = res_entry_q.address;
  assign out_transaction_o = res_entry_q.transaction;
  assign out_payload_o     = res_entry_q.payload;
  assign last_o            = res_last_q;

endmodule

@@ hw/rtl/armq_checker.sv @@
// Port-level checker for the retransmission queue, with its bind statement.
// Depends on armq_pkg for the kind and status codes.
module armq_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic [armq_pkg::KindW-1:0]    kind_i,
  input logic                          result_valid_o,
  input logic [armq_pkg::StatusW-1:0]  status_o,
  input logic [armq_pkg::TypeW-1:0]    out_type_o,
  input logic [armq_pkg::AddressW-1:0] out_address_o,
  input logic                          last_o
);
  import armq_pkg::*;

  // An accepted item of a known kind keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (kind_i != KIND_UNUSED)) |=> busy)
    else $error("accepted item did not raise busy");

  // Results come only out of work that was in progress.
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result without an item in progress");

  // Only retries are followed by further results of the same item.
  a_last_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (last_o == (status_o != ST_RETRY)))
    else $error("last flag disagrees with status");

  // The final result of an item leaves the block ready for the next one.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |-> !busy)
    else $error("busy after the final result");

  // The type and address fields are zero on every result other than a retry.
  a_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (status_o != ST_RETRY)) |->
      ((out_type_o == '0) && (out_address_o == '0)))
    else $error("entry fields set on a non-retry result");

endmodule

bind ack_retry_message_queue armq_checker u_armq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .kind_i         (kind_i),
  .result_valid_o (result_valid_o),
  .status_o       (status_o),
  .out_type_o     (out_type_o),
  .out_address_o  (out_address_o),
  .last_o         (last_o)
);
